/* design/iap_pkg.sv */
package iap_pkg;

  // Fixed field widths of the request, result and register.
  localparam int SLOT_W   = 16;
  localparam int GRANT_W  = 10;
  localparam int LIMIT_W  = 11;
  localparam int STATUS_W = 2;

  // Register value after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // Request operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Controls for the free stack.
  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
  } stack_ctrl_t;

  // Controls for the live mark table.
  typedef struct packed {
    logic rd;
    logic wr;
    logic wr_val;
  } live_ctrl_t;

endpackage

/* design/iap_free_stack.sv */
module iap_free_stack #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  iap_pkg::stack_ctrl_t ctrl,
  input  logic [AW-1:0]       push_data,
  output logic [AW-1:0]       top_data,
  output logic [CW-1:0]       count
);
  import iap_pkg::*;

  logic [AW-1:0] mem [DEPTH];
  logic [CW-1:0] count_m1;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // The top entry sits one below the fill count; a push lands at the count.
  assign count_m1 = count - CW'(1);
  assign rd_addr  = count_m1[AW-1:0];
  assign wr_addr  = count[AW-1:0];

  // Stack memory with a registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      top_data <= mem[rd_addr];
    end
    if (ctrl.push) begin
      mem[wr_addr] <= push_data;
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CW'(1);
    end else if (ctrl.pop) begin
      count <= count_m1;
    end
  end

endmodule

/* design/iap_live_table.sv */
module iap_live_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  iap_pkg::live_ctrl_t ctrl,
  input  logic [AW-1:0]      rd_addr,
  input  logic [AW-1:0]      wr_addr,
  output logic               rd_data,
  output logic               ready
);
  import iap_pkg::*;

  logic          mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] clr_ptr;

  assign ready = ~clearing;

  // After reset, sweep the table once to clear every live mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + AW'(1);
      if (clr_ptr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port shared by the sweep and normal updates.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr] <= 1'b0;
    end else if (ctrl.wr) begin
      mem[wr_addr] <= ctrl.wr_val;
    end
    if (ctrl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/index_pool_allocator_unit.sv */
// An accepted transaction passes through S_POP and S_LIVE; its done strobe is
// registered in S_LIVE. A new transaction is taken only after the last is done,
// as busy covers the two dependent memory reads (free stack top, then the live
// mark of the chosen slot). Reset: synchronous; afterwards busy stays high while
// the live mark table is swept to zero. Configuration writes are taken always.
// The result is shown for one cycle with done high; the receiver cannot stall.
module index_pool_allocator_unit #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [iap_pkg::SLOT_W-1:0]    slot_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [iap_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                          done,
  output logic [iap_pkg::GRANT_W-1:0]   granted_index,
  output logic [iap_pkg::STATUS_W-1:0]  status,
  output logic                          prior_live
);
  import iap_pkg::*;

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_LIVE} state_t;

  state_t               state;
  logic                 func_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [LIMIT_W-1:0]   pool_limit;
  logic [LIMIT_W-1:0]   eff_limit;
  logic [CW-1:0]        next_fresh;
  logic [AW-1:0]        idx_r;
  status_t              stat_r;
  logic                 live_rd_r;
  logic                 live_wr_r;

  stack_ctrl_t          stack_ctrl;
  live_ctrl_t           live_ctrl;
  logic [AW-1:0]        top_data;
  logic [CW-1:0]        free_count;
  logic                 live_rdata;
  logic                 live_ready;

  logic [AW-1:0]        dec_idx;
  status_t              dec_status;
  logic                 dec_live_rd;
  logic                 dec_live_wr;
  logic                 dec_push;
  logic                 dec_pop;
  logic                 dec_bump;
  logic                 accept;
  logic [31:0]          idx_wide;

  assign busy      = (state != S_IDLE) | ~live_ready;
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pool_limit <= cfg_data;
    end
  end

  // The usable limit never exceeds the pool depth.
  always_comb begin
    if (32'(pool_limit) > 32'(POOL_DEPTH)) begin
      eff_limit = LIMIT_W'(POOL_DEPTH);
    end else begin
      eff_limit = pool_limit;
    end
  end

  // Decide the outcome once the stack top has been read.
  always_comb begin
    dec_idx     = next_fresh[AW-1:0];
    dec_status  = ST_OK;
    dec_live_rd = 1'b0;
    dec_live_wr = 1'b0;
    dec_push    = 1'b0;
    dec_pop     = 1'b0;
    dec_bump    = 1'b0;
    if (func_r == FUNC_ALLOC) begin
      priority if (free_count != '0) begin
        dec_idx     = top_data;
        dec_pop     = 1'b1;
        dec_live_rd = 1'b1;
        dec_live_wr = 1'b1;
      end else if (32'(next_fresh) < 32'(eff_limit)) begin
        dec_bump    = 1'b1;
        dec_live_rd = 1'b1;
        dec_live_wr = 1'b1;
      end else begin
        dec_status = ST_EXHAUSTED;
      end
    end else begin
      dec_idx = slot_r[AW-1:0];
      priority if (32'(slot_r) >= 32'(eff_limit)) begin
        dec_status = ST_RANGE;
      end else if (free_count == CW'(POOL_DEPTH)) begin
        dec_status  = ST_FULL;
        dec_live_rd = 1'b1;
      end else begin
        dec_push    = 1'b1;
        dec_live_rd = 1'b1;
        dec_live_wr = 1'b1;
      end
    end
  end

  // Memory controls.
  always_comb begin
    stack_ctrl.rd    = accept;
    stack_ctrl.push  = (state == S_POP) & dec_push;
    stack_ctrl.pop   = (state == S_POP) & dec_pop;
    live_ctrl.rd     = (state == S_POP) & dec_live_rd;
    live_ctrl.wr     = (state == S_LIVE) & live_wr_r;
    live_ctrl.wr_val = (func_r == FUNC_ALLOC);
  end

  assign idx_wide = 32'(idx_r);

  // Sequencer with registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_fresh <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_r <= func;
            slot_r <= slot_index;
            state  <= S_POP;
          end
        end
        S_POP: begin
          idx_r     <= dec_idx;
          stat_r    <= dec_status;
          live_rd_r <= dec_live_rd;
          live_wr_r <= dec_live_wr;
          if (dec_bump) begin
            next_fresh <= next_fresh + CW'(1);
          end
          state <= S_LIVE;
        end
        S_LIVE: begin
          done       <= 1'b1;
          status     <= stat_r;
          prior_live <= live_rd_r & live_rdata;
          if (func_r == FUNC_ALLOC && stat_r == ST_OK) begin
            granted_index <= idx_wide[GRANT_W-1:0];
          end else begin
            granted_index <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  iap_free_stack #(
    .DEPTH (POOL_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (stack_ctrl),
    .push_data (slot_r[AW-1:0]),
    .top_data  (top_data),
    .count     (free_count)
  );

  iap_live_table #(
    .DEPTH (POOL_DEPTH)
  ) u_live (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (live_ctrl),
    .rd_addr (dec_idx),
    .wr_addr (idx_r),
    .rd_data (live_rdata),
    .ready   (live_ready)
  );

endmodule
